/* rtl/core/mhpq_pkg.sv */
// Package with the types and constants of the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

  localparam int unsigned HEAP_DEPTH = 256;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned KEY_W      = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    key_t    removed_key;
    logic    top_valid;
    key_t    top_key;
    cnt_t    entry_count;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/mhpq_req_if.sv */
// Request channel of the min-heap priority queue.
`default_nettype none

interface mhpq_req_if;
  logic                valid;
  logic                ready;
  logic                func;
  mhpq_pkg::key_t      key_in;

  modport source (output valid, output func, output key_in, input ready);
  modport sink   (input valid, input func, input key_in, output ready);
endinterface

`default_nettype wire

/* rtl/core/mhpq_rsp_if.sv */
// Result channel of the min-heap priority queue.
`default_nettype none

interface mhpq_rsp_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  mhpq_pkg::key_t      removed_key;
  logic                top_valid;
  mhpq_pkg::key_t      top_key;
  mhpq_pkg::cnt_t      entry_count;

  modport source (output valid, output status, output removed_key, output top_valid,
                  output top_key, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_key, input top_valid,
                  input top_key, input entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/mhpq_rsp_buf.sv */
// Output register that holds one finished result until the sink takes it.
`default_nettype none

module mhpq_rsp_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mhpq_pkg::rsp_t data_i,
  output logic                ready_o,
  mhpq_rsp_if.source          rsp_o
);

  logic           full_q, full_d;
  mhpq_pkg::rsp_t data_q;

  assign ready_o = !full_q || rsp_o.ready;

  always_comb begin
    full_d = full_q;
    if (rsp_o.ready) begin
      full_d = 1'b0;
    end
    if (push_i) begin
      full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid       = full_q;
  assign rsp_o.status      = data_q.status;
  assign rsp_o.removed_key = data_q.removed_key;
  assign rsp_o.top_valid   = data_q.top_valid;
  assign rsp_o.top_key     = data_q.top_key;
  assign rsp_o.entry_count = data_q.entry_count;

endmodule

`default_nettype wire

/* rtl/core/min_heap_priority_queue.sv */
// Top level of the binary min-heap priority queue with its heap memory and sift sequencer.
// An insert climbs from the new leaf towards the root; an extract moves the last entry to the
// root and sinks it towards the leaves. Each level takes a read state and then a compare state.
// A rejected request (full or empty heap), or an extract that empties the heap, goes straight
// to the done state. Only one request is handled at a time: a new one is taken only in idle.
// Reset empties the heap at once; the RAM itself is not cleared and needs no clearing pass.
`default_nettype none

module min_heap_priority_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mhpq_req_if.sink   req_i,
  mhpq_rsp_if.source rsp_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_RD  = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_EX_LD  = 7'b0001000,
    S_DN_RD  = 7'b0010000,
    S_DN_CMP = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  mhpq_pkg::cnt_t      cnt_q, cnt_d;
  mhpq_pkg::addr_t     pos_q, pos_d;
  mhpq_pkg::key_t      key_q, key_d;
  mhpq_pkg::key_t      removed_q, removed_d;
  mhpq_pkg::status_e   status_q, status_d;
  logic                right_ok_q, right_ok_d;
  mhpq_pkg::key_t      top_q;

  mhpq_pkg::key_t      mem [mhpq_pkg::HEAP_DEPTH];
  mhpq_pkg::key_t      rdata_a_q, rdata_b_q;
  mhpq_pkg::addr_t     raddr_a, raddr_b;
  logic                we;
  mhpq_pkg::addr_t     waddr;
  mhpq_pkg::key_t      wdata;

  logic                accept;
  logic                push;
  logic                buf_ready;
  mhpq_pkg::rsp_t      rsp;
  mhpq_pkg::cnt_t      cnt_dec;
  mhpq_pkg::cnt_t      left_w;
  mhpq_pkg::addr_t     parent;
  logic                pick_right;
  mhpq_pkg::key_t      pick_val;
  mhpq_pkg::addr_t     pick_addr;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cnt_dec     = cnt_q - mhpq_pkg::CNT_W'(1);
  assign left_w      = {pos_q, 1'b1};
  assign parent      = mhpq_pkg::ADDR_W'((pos_q - mhpq_pkg::ADDR_W'(1)) >> 1);
  assign pick_right  = right_ok_q && (rdata_b_q < rdata_a_q);
  assign pick_val    = pick_right ? rdata_b_q : rdata_a_q;
  assign pick_addr   = left_w[mhpq_pkg::ADDR_W-1:0] + mhpq_pkg::ADDR_W'(pick_right);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    key_d      = key_q;
    removed_d  = removed_q;
    status_d   = status_q;
    right_ok_d = right_ok_q;
    raddr_a    = left_w[mhpq_pkg::ADDR_W-1:0];
    raddr_b    = left_w[mhpq_pkg::ADDR_W-1:0] + mhpq_pkg::ADDR_W'(1);
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = key_q;
    push       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        raddr_a = cnt_dec[mhpq_pkg::ADDR_W-1:0];
        if (accept) begin
          status_d  = mhpq_pkg::STATUS_OK;
          removed_d = '0;
          if (req_i.func == mhpq_pkg::FUNC_INSERT) begin
            if (cnt_q == mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH)) begin
              status_d = mhpq_pkg::STATUS_FULL;
              state_d  = S_DONE;
            end else begin
              key_d   = req_i.key_in;
              pos_d   = cnt_q[mhpq_pkg::ADDR_W-1:0];
              cnt_d   = cnt_q + mhpq_pkg::CNT_W'(1);
              state_d = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = mhpq_pkg::STATUS_EMPTY;
              state_d  = S_DONE;
            end else begin
              removed_d = top_q;
              cnt_d     = cnt_dec;
              state_d   = (cnt_dec == '0) ? S_DONE : S_EX_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        raddr_a = parent;
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (key_q < rdata_a_q) begin
          wdata   = rdata_a_q;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EX_LD: begin
        key_d   = rdata_a_q;
        pos_d   = '0;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        right_ok_d = (left_w + mhpq_pkg::CNT_W'(1)) < cnt_q;
        if (left_w >= cnt_q) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (pick_val < key_q) begin
          wdata   = pick_val;
          pos_d   = pick_addr;
          state_d = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (buf_ready) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    key_q      <= key_d;
    removed_q  <= removed_d;
    status_q   <= status_d;
    right_ok_q <= right_ok_d;
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_q <= mem[raddr_a];
    rdata_b_q <= mem[raddr_b];
  end

  always_comb begin
    rsp.status      = status_q;
    rsp.removed_key = removed_q;
    rsp.top_valid   = (cnt_q != '0);
    rsp.top_key     = (cnt_q != '0) ? top_q : '0;
    rsp.entry_count = cnt_q;
  end

  mhpq_rsp_buf u_rsp_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rsp),
    .ready_o (buf_ready),
    .rsp_o   (rsp_o)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH))
    else $error("Entry count exceeds the heap depth.");

  a_pos_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_CMP || state_q == S_DN_CMP) |-> ({1'b0, pos_q} < cnt_q))
    else $error("Sift position lies outside the held entries.");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("Sequencer returned to idle right after a request transfer.");

  a_write_in_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_UP_RD || state_q == S_UP_CMP || state_q == S_DN_RD ||
            state_q == S_DN_CMP))
    else $error("Heap memory written outside a sift step.");

  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (state_q == S_IDLE))
    else $error("Result handed over without returning to idle.");

endmodule

`default_nettype wire
